[hw/rtl/scfp_pkg.sv]
// ----------------------------------------------------------------------------
// scfp_pkg: shared types for the sum-checked frame parser
// Phase codes, result kinds, configuration register indexes and the
// result and configuration structures passed between the modules.
// ----------------------------------------------------------------------------
package scfp_pkg;

    localparam int unsigned ByteW = 8;

    // Parser phases. Unused codes behave as hunting.
    typedef enum logic [2:0] {
        PH_HUNT  = 3'd0,
        PH_ID    = 3'd1,
        PH_LEN   = 3'd2,
        PH_DATA  = 3'd3,
        PH_CHECK = 3'd4
    } phase_t;

    // Kind of a result transaction.
    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_GOOD    = 2'd1,
        KIND_BAD     = 2'd2
    } kind_t;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        REG_SYNC_VALUE   = 1'b0,
        REG_CHECK_ENABLE = 1'b1
    } cfg_reg_t;

    localparam logic [ByteW-1:0] SyncReset = 8'd254;

    typedef struct packed {
        logic [ByteW-1:0] sync_value;
        logic             check_enable;
    } cfg_t;

    typedef struct packed {
        kind_t            kind;
        logic [ByteW-1:0] frame_size;
        logic [ByteW-1:0] frame_tag;
        logic [ByteW-1:0] payload_position;
        logic [ByteW-1:0] payload_value;
    } result_t;

endpackage

[hw/rtl/scfp_parser.sv]
// ----------------------------------------------------------------------------
// scfp_parser: per-byte frame state update
// Holds the parse phase, frame id, length, byte count and running sum, and
// forms at most one result for each accepted byte.
// ----------------------------------------------------------------------------
module scfp_parser (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           step,
    input  logic [scfp_pkg::ByteW-1:0]     rx_byte,
    input  scfp_pkg::cfg_t                 cfg,
    output logic                           res_valid,
    output scfp_pkg::result_t              res
);

    scfp_pkg::phase_t            phase_reg, phase_next;
    logic [scfp_pkg::ByteW-1:0]  tag_reg, tag_next;
    logic [scfp_pkg::ByteW-1:0]  size_reg, size_next;
    logic [scfp_pkg::ByteW-1:0]  seen_reg, seen_next;
    logic [scfp_pkg::ByteW-1:0]  sum_reg, sum_next;
    logic [scfp_pkg::ByteW-1:0]  sum_add;
    logic [scfp_pkg::ByteW-1:0]  seen_inc;

    assign sum_add  = sum_reg + rx_byte;
    assign seen_inc = seen_reg + 8'd1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= scfp_pkg::PH_HUNT;
            tag_reg   <= '0;
            size_reg  <= '0;
            seen_reg  <= '0;
            sum_reg   <= '0;
        end else if (step) begin
            phase_reg <= phase_next;
            tag_reg   <= tag_next;
            size_reg  <= size_next;
            seen_reg  <= seen_next;
            sum_reg   <= sum_next;
        end
    end

    always_comb begin
        phase_next = phase_reg;
        tag_next   = tag_reg;
        size_next  = size_reg;
        seen_next  = seen_reg;
        sum_next   = sum_reg;
        res_valid  = 1'b0;
        res.kind             = scfp_pkg::KIND_PAYLOAD;
        res.payload_value    = '0;
        res.payload_position = '0;
        res.frame_tag        = tag_reg;
        res.frame_size       = size_reg;

        unique case (phase_reg)
            scfp_pkg::PH_ID: begin
                tag_next   = rx_byte;
                sum_next   = sum_add;
                phase_next = scfp_pkg::PH_LEN;
            end
            scfp_pkg::PH_LEN: begin
                size_next  = rx_byte;
                seen_next  = '0;
                sum_next   = sum_add;
                phase_next = (rx_byte == '0) ? scfp_pkg::PH_CHECK : scfp_pkg::PH_DATA;
            end
            scfp_pkg::PH_DATA: begin
                res_valid            = step;
                res.payload_value    = rx_byte;
                res.payload_position = seen_reg;
                seen_next            = seen_inc;
                sum_next             = sum_add;
                if (seen_inc == size_reg) begin
                    phase_next = scfp_pkg::PH_CHECK;
                end
            end
            scfp_pkg::PH_CHECK: begin
                res_valid = step;
                res.kind  = (!cfg.check_enable || rx_byte == sum_reg) ?
                            scfp_pkg::KIND_GOOD : scfp_pkg::KIND_BAD;
                phase_next = scfp_pkg::PH_HUNT;
                tag_next   = '0;
                size_next  = '0;
                seen_next  = '0;
                sum_next   = '0;
            end
            default: begin
                // Hunting; unused codes fall back here as well.
                if (rx_byte == cfg.sync_value) begin
                    sum_next   = rx_byte;
                    phase_next = scfp_pkg::PH_ID;
                end else begin
                    phase_next = scfp_pkg::PH_HUNT;
                end
            end
        endcase
    end

`ifndef ASSERT_OFF
    // A verdict always returns the parser to hunting.
    a_check_to_hunt: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && phase_reg == scfp_pkg::PH_CHECK) |=> phase_reg == scfp_pkg::PH_HUNT)
        else $error("parser did not return to hunting after a verdict");

    // While reading payload the count stays below the declared length.
    a_count_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == scfp_pkg::PH_DATA) |-> (seen_reg < size_reg))
        else $error("payload count reached the frame length inside the data phase");

    // Results come only from payload or checksum bytes.
    a_result_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> (step && (phase_reg == scfp_pkg::PH_DATA ||
                                phase_reg == scfp_pkg::PH_CHECK)))
        else $error("result raised outside the data or checksum phase");
`endif

endmodule

[hw/rtl/scfp_out_buf.sv]
// ----------------------------------------------------------------------------
// scfp_out_buf: result register with skid stage
// Holds the result transaction for the master side and catches one more
// result while the consumer stalls, so the input side can keep going.
// ----------------------------------------------------------------------------
module scfp_out_buf (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    input  scfp_pkg::result_t  in_data,
    output logic               in_ready,
    output logic               out_valid,
    output scfp_pkg::result_t  out_data,
    input  logic               out_ready
);

    logic              main_valid_reg;
    scfp_pkg::result_t main_data_reg;
    logic              skid_valid_reg;
    scfp_pkg::result_t skid_data_reg;
    logic              main_free;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;
    assign main_free = !main_valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (main_free) begin
            if (skid_valid_reg) begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                main_valid_reg <= in_valid;
            end
        end else if (in_valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (main_free) begin
            if (skid_valid_reg) begin
                main_data_reg <= skid_data_reg;
            end else if (in_valid) begin
                main_data_reg <= in_data;
            end
        end else if (in_valid) begin
            skid_data_reg <= in_data;
        end
    end

`ifndef ASSERT_OFF
    // The skid stage is only ever filled behind a full main register.
    a_skid_behind_main: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid stage holds data while the main register is empty");

    // No result arrives while the skid stage is occupied.
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid |-> in_ready)
        else $error("result pushed while the buffer was full");

    // A stalled full buffer keeps the skid stage until the consumer takes data.
    a_skid_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_valid_reg && !out_ready) |=> skid_valid_reg)
        else $error("skid entry lost during a stall");
`endif

endmodule

[hw/rtl/sum_checked_frame_parser.sv]
// ----------------------------------------------------------------------------
// sum_checked_frame_parser: sync-byte framed packet parser, additive checksum
// Hunts for the sync byte, then reads id, length, payload and checksum.
// Payload bytes are forwarded as they arrive; the checksum byte yields a
// good or bad frame verdict.
// ----------------------------------------------------------------------------
// Output: a result is registered in the output buffer before it reaches m_tvalid.
// Throughput: one byte per cycle while s_tready is high; the frame state
// registers update on every accepted byte. A two-entry output buffer takes
// one more result transaction while the master side stalls, and s_tready
// falls once both entries are full.
// Reset: synchronous, active low; parser returns to hunting, registers take
// sync_value 254 and check_enable 1, output buffer empties.
// ----------------------------------------------------------------------------
module sum_checked_frame_parser (
    input  logic        aclk,
    input  logic        aresetn,

    // Received byte stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte

    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] payload_value, [15:8] payload_position,
                                   // [23:16] frame_tag, [31:24] frame_size
    output logic [1:0]  m_tuser,   // [1:0] item_kind

    // Configuration write port.
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [7:0]  cfg_wdata
);

    scfp_pkg::cfg_t    cfg_reg;
    logic              step;
    logic              res_valid;
    scfp_pkg::result_t res;
    scfp_pkg::result_t out_res;

    // Configuration registers. Writes take effect at once: the sync value
    // is only consulted while hunting, the check enable only on the
    // checksum byte.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sync_value   <= scfp_pkg::SyncReset;
            cfg_reg.check_enable <= 1'b1;
        end else if (cfg_we) begin
            unique case (scfp_pkg::cfg_reg_t'(cfg_index))
                scfp_pkg::REG_SYNC_VALUE:   cfg_reg.sync_value   <= cfg_wdata;
                scfp_pkg::REG_CHECK_ENABLE: cfg_reg.check_enable <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // A byte transaction advances the parser by exactly one step.
    assign step = s_tvalid && s_tready;

    // Frame state update and result formation; only payload and checksum
    // bytes produce a result.
    scfp_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .rx_byte   (s_tdata),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    // Result register plus skid stage. Ready only depends on the skid
    // stage, so a byte that yields no result is also held back while the
    // buffer is full; this keeps the parser state in step with the output.
    scfp_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (res_valid),
        .in_data   (res),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_data  (out_res),
        .out_ready (m_tready)
    );

    assign m_tdata = {out_res.frame_size, out_res.frame_tag,
                      out_res.payload_position, out_res.payload_value};
    assign m_tuser = out_res.kind;

endmodule

[test/sum_checked_frame_parser_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sum_checked_frame_parser_test: self-checking bench for the frame parser
// Streams received bytes into the parser and checks every result transaction
// against an in-bench model of the hunt, id, length, payload and checksum
// phases. Both stream sides idle at random. The configuration is changed
// between phases of the run, once the byte stream has drained; one change
// is made while a frame is half read.
// ----------------------------------------------------------------------------
module sum_checked_frame_parser_test;

    // One expected result transaction, held in the order the parser emits them.
    typedef struct packed {
        scfp_pkg::kind_t kind;
        logic [7:0]      pay;
        logic [7:0]      pos;
        logic [7:0]      tag;
        logic [7:0]      len;
    } frame_item_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;

    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'd0;   // [7:0] rx_byte

    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;            // [7:0] payload_value, [15:8] payload_position,
                                     // [23:16] frame_tag, [31:24] frame_size
    logic [1:0]  m_tuser;            // [1:0] item_kind

    logic                cfg_we    = 1'b0;
    scfp_pkg::cfg_reg_t  cfg_index = scfp_pkg::REG_SYNC_VALUE;
    logic [7:0]          cfg_wdata = 8'd0;

    // Bytes waiting to be offered, and results the parser still owes us.
    logic [7:0]  rx_backlog[$];
    frame_item_t expected_items[$];

    // Parser model: configuration as last written, and the frame in progress.
    logic [7:0]        sync_cfg  = scfp_pkg::SyncReset;
    logic              chk_cfg   = 1'b1;
    scfp_pkg::phase_t  phase_q   = scfp_pkg::PH_HUNT;
    logic [7:0]        tag_q     = 8'd0;
    logic [7:0]        len_q     = 8'd0;
    logic [7:0]        seen_q    = 8'd0;
    logic [7:0]        sum_q     = 8'd0;

    // Random idling is switched off for some stretches and for the tail of the run.
    logic        idle_on   = 1'b1;
    int          src_gap   = 0;
    int          sink_gap  = 0;
    // Each increment of hold_reqs asks the sink for one long hold-off.
    int          hold_reqs = 0;
    int          hold_served = 0;
    int          hold_left = 0;

    int          frame_bytes = 0;
    int          errors    = 0;

    sum_checked_frame_parser uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    // Advance the frame model by one accepted byte and queue what it yields.
    // A sync byte seen inside a frame is plain data; only hunting looks for it.
    task automatic parse_byte(input logic [7:0] b);
        frame_item_t r;
        case (phase_q)
            scfp_pkg::PH_ID: begin
                tag_q   = b;
                sum_q   = sum_q + b;
                phase_q = scfp_pkg::PH_LEN;
            end
            scfp_pkg::PH_LEN: begin
                len_q   = b;
                seen_q  = 8'd0;
                sum_q   = sum_q + b;
                // A zero length skips the payload and goes to the checksum.
                phase_q = (b == 8'd0) ? scfp_pkg::PH_CHECK : scfp_pkg::PH_DATA;
            end
            scfp_pkg::PH_DATA: begin
                r.kind = scfp_pkg::KIND_PAYLOAD;
                r.pay  = b;
                r.pos  = seen_q;
                r.tag  = tag_q;
                r.len  = len_q;
                expected_items.push_back(r);
                seen_q = seen_q + 8'd1;
                sum_q  = sum_q + b;
                if (seen_q == len_q) begin
                    phase_q = scfp_pkg::PH_CHECK;
                end
            end
            scfp_pkg::PH_CHECK: begin
                // With checking off every completed frame passes.
                r.kind = (!chk_cfg || b == sum_q) ? scfp_pkg::KIND_GOOD
                                                  : scfp_pkg::KIND_BAD;
                r.pay  = 8'd0;
                r.pos  = 8'd0;
                r.tag  = tag_q;
                r.len  = len_q;
                expected_items.push_back(r);
                phase_q = scfp_pkg::PH_HUNT;
                tag_q   = 8'd0;
                len_q   = 8'd0;
                seen_q  = 8'd0;
                sum_q   = 8'd0;
            end
            default: begin
                // Hunting, and any phase code that should never occur.
                if (b == sync_cfg) begin
                    sum_q   = b;
                    phase_q = scfp_pkg::PH_ID;
                end else begin
                    phase_q = scfp_pkg::PH_HUNT;
                end
            end
        endcase
    endtask

    task automatic note_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t on %s: got %0h, want %0h", $realtime, what, got, want);
        errors++;
    endtask

    // Queue a complete frame built on the current sync value. A spoiled frame
    // carries a checksum that is off by a nonzero amount.
    task automatic queue_frame(input logic [7:0] tag, input int len, input bit spoil);
        logic [7:0] sum;
        logic [7:0] b;
        sum = sync_cfg + tag + len[7:0];
        rx_backlog.push_back(sync_cfg);
        rx_backlog.push_back(tag);
        rx_backlog.push_back(len[7:0]);
        for (int i = 0; i < len; i++) begin
            b = $urandom_range(0, 255);
            sum = sum + b;
            rx_backlog.push_back(b);
        end
        if (spoil) begin
            sum = sum + 8'($urandom_range(1, 255));
        end
        rx_backlog.push_back(sum);
        frame_bytes += len + 4;
    endtask

    // Register writes follow wait_idle; no check that the parser is idle.
    // The model takes the new value at the edge where the write lands.
    task automatic write_reg(input scfp_pkg::cfg_reg_t idx, input logic [7:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        if (idx == scfp_pkg::REG_SYNC_VALUE) begin
            sync_cfg = val;
        end else begin
            chk_cfg = val[0];
        end
    endtask

    // Wait until everything offered is taken and every owed result is in.
    // The idle test runs at the falling edge, clear of the rising-edge
    // updates. A byte that yields no result may still be in the parser, so
    // further rising edges pass before the task returns.
    task automatic wait_idle();
        do begin
            @(negedge aclk);
        end while (rx_backlog.size() != 0 || s_tvalid || expected_items.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    // Sender: offers the backlog one transaction at a time, with random gaps.
    always @(posedge aclk) begin : byte_driver
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            src_gap  <= 0;
        end else if (!s_tvalid || s_tready) begin
            if (src_gap > 0) begin
                src_gap  <= src_gap - 1;
                s_tvalid <= 1'b0;
            end else if (rx_backlog.size() != 0) begin
                s_tdata  <= rx_backlog.pop_front();
                s_tvalid <= 1'b1;
                if (idle_on && $urandom_range(0, 7) == 0) begin
                    src_gap <= $urandom_range(1, 6);
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: stalls in short random bursts, and holds off for a long
    // stretch whenever a hold is requested, so the parser fills and backs up.
    always @(posedge aclk) begin : result_sink
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_served != hold_reqs) begin
            hold_served <= hold_reqs;
            hold_left   <= 150;
            m_tready    <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap <= sink_gap - 1;
            m_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            sink_gap <= $urandom_range(0, 5);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Monitor: the model takes each accepted byte first, so a result in the
    // same edge always finds its expectation; then the result is checked.
    always @(posedge aclk) begin : frame_monitor
        frame_item_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                parse_byte(s_tdata);
            end
            if (m_tvalid && m_tready) begin
                if (expected_items.size() == 0) begin
                    note_mismatch("unexpected result", m_tuser, 0);
                end else begin
                    want = expected_items.pop_front();
                    if (m_tuser != want.kind)
                        note_mismatch("item_kind", m_tuser, want.kind);
                    if (m_tdata[7:0] != want.pay)
                        note_mismatch("payload_value", m_tdata[7:0], want.pay);
                    if (m_tdata[15:8] != want.pos)
                        note_mismatch("payload_position", m_tdata[15:8], want.pos);
                    if (m_tdata[23:16] != want.tag)
                        note_mismatch("frame_tag", m_tdata[23:16], want.tag);
                    if (m_tdata[31:24] != want.len)
                        note_mismatch("frame_size", m_tdata[31:24], want.len);
                end
            end
        end
    end

    // Stimulus sequence.
    initial begin
        int seg;
        int seg_start;
        int pick;
        int len;
        int cut;
        int strays;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part, on the reset configuration (sync 254, checking on).
        // Bytes outside a frame are ignored, extremes of the byte included.
        rx_backlog.push_back(8'h00);
        rx_backlog.push_back(8'hFF);
        // Zero length: the length byte is followed directly by the checksum.
        queue_frame(8'h00, 0, 1'b0);
        queue_frame(8'hFF, 2, 1'b0);
        queue_frame(8'h3C, 1, 1'b1);
        // Sync value used as id, as payload data and as checksum input.
        rx_backlog.push_back(8'hFE);
        rx_backlog.push_back(8'hFE);
        rx_backlog.push_back(8'h02);
        rx_backlog.push_back(8'hFE);
        rx_backlog.push_back(8'hFE);
        rx_backlog.push_back(8'hFE + 8'hFE + 8'h02 + 8'hFE + 8'hFE);
        wait_idle();

        // Open a frame, then change both registers while it is half read.
        // The frame keeps the sum it started with; with checking now off,
        // a wrong checksum still gives a good verdict.
        rx_backlog.push_back(sync_cfg);
        rx_backlog.push_back(8'h5A);
        rx_backlog.push_back(8'h03);
        rx_backlog.push_back(8'h11);
        rx_backlog.push_back(8'h22);
        wait_idle();
        write_reg(scfp_pkg::REG_SYNC_VALUE, 8'h00);
        write_reg(scfp_pkg::REG_CHECK_ENABLE, 8'h00);
        rx_backlog.push_back(8'h33);
        rx_backlog.push_back(8'h00);
        wait_idle();

        // Random part: phases of well-formed frames with random content,
        // some spoiled, plus stray bytes and cut-off frames. Each phase starts
        // once the stream has drained, with a fresh configuration.
        frame_bytes = 0;
        seg = 0;
        while (frame_bytes < 560) begin
            wait_idle();
            case (seg)
                0: begin
                    write_reg(scfp_pkg::REG_SYNC_VALUE, 8'h00);
                    write_reg(scfp_pkg::REG_CHECK_ENABLE, 8'h01);
                end
                1: begin
                    write_reg(scfp_pkg::REG_SYNC_VALUE, 8'hFF);
                    write_reg(scfp_pkg::REG_CHECK_ENABLE, 8'h00);
                end
                default: begin
                    write_reg(scfp_pkg::REG_SYNC_VALUE, 8'($urandom_range(0, 255)));
                    write_reg(scfp_pkg::REG_CHECK_ENABLE,
                              ($urandom_range(0, 3) != 0) ? 8'h01 : 8'h00);
                end
            endcase
            // Quiet stretches now and then, and none at all near the end.
            @(posedge aclk);
            idle_on <= (seg % 3 != 2) && (frame_bytes < 200);

            seg_start = frame_bytes;
            if (seg == 3) begin
                // Longest frame: payload positions run up to 254.
                queue_frame(8'($urandom_range(0, 255)), 255, 1'b0);
            end
            while (frame_bytes - seg_start < 80) begin
                pick = $urandom_range(0, 19);
                if (pick < 15) begin
                    len = ($urandom_range(0, 15) == 0) ? $urandom_range(13, 64)
                                                       : $urandom_range(0, 12);
                    queue_frame(8'($urandom_range(0, 255)), len,
                                $urandom_range(0, 3) == 0);
                end else if (pick < 18) begin
                    strays = $urandom_range(1, 3);
                    repeat (strays)
                        rx_backlog.push_back(8'($urandom_range(0, 255)));
                    frame_bytes += strays;
                end else begin
                    // A frame cut short: the next bytes are read as its rest.
                    len = $urandom_range(1, 8);
                    cut = $urandom_range(0, len - 1);
                    rx_backlog.push_back(sync_cfg);
                    rx_backlog.push_back(8'($urandom_range(0, 255)));
                    rx_backlog.push_back(len[7:0]);
                    repeat (cut) rx_backlog.push_back(8'($urandom_range(0, 255)));
                    frame_bytes += cut + 3;
                end
            end
            // With a full backlog offered, the receiver holds off for a while.
            if (seg == 2) begin
                @(posedge aclk);
                hold_reqs <= hold_reqs + 1;
            end
            seg++;
        end

        wait_idle();
        repeat (8) @(posedge aclk);
        if (errors == 0 && expected_items.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
